// ===== rtl/pbisc_pkg.sv =====
// Shared types and constants for the power-button and idle-sleep controller.
`timescale 1ns / 1ps
package pbisc_pkg;

    // Width of the internal time base; timestamps wrap modulo 2^TIME_BITS
    localparam int TIME_BITS = 32;
    // Width used for compares of idle time against the 32-bit timeouts
    localparam int CMP_BITS  = (TIME_BITS > 32) ? TIME_BITS : 32;

    localparam logic [15:0] SHORT_PRESS_RST = 16'd800;
    localparam logic [15:0] WAKE_HOLD_RST   = 16'd2000;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [CMP_BITS-1:0]  t_cmp;
    typedef logic [31:0]          t_stamp;
    typedef logic [15:0]          t_ms16;
    typedef logic [2:0]           t_cmd_bits;
    typedef logic [2:0]           t_cfg_idx;
    typedef logic [31:0]          t_cfg_data;

    // Event commands
    typedef enum logic [2:0] {
        CMD_WAKE_HOLD       = 3'd0,
        CMD_CONSUME_RELEASE = 3'd1,
        CMD_NOTE_ACTIVITY   = 3'd2,
        CMD_POLL_HOLD       = 3'd3,
        CMD_SLEEP_CHECK     = 3'd4,
        CMD_TILT_TOGGLE     = 3'd5
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_TRUE_SLEEP_TIMEOUT = 3'd0,
        REG_GYRO_OFF_TIMEOUT   = 3'd1,
        REG_TILT_PAGE_TURN     = 3'd2,
        REG_SHORT_PRESS        = 3'd3,
        REG_WAKE_HOLD          = 3'd4
    } t_reg_idx;

endpackage

// ===== rtl/pbisc_if.sv =====
// Handshake channel interfaces: event input, result output and config write.
`timescale 1ns / 1ps
interface pbisc_in_if;
    import pbisc_pkg::*;
    logic      valid;
    logic      ready;
    t_cmd_bits command;
    t_stamp    now_ms;
    logic      power_pressed;
    logic      power_released;
    t_ms16     held_ms;
    logic      any_pressed;
    logic      any_released;
    logic      tilt_activity;
    logic      sleep_blocked;

    modport source (
        output valid, command, now_ms, power_pressed, power_released, held_ms,
               any_pressed, any_released, tilt_activity, sleep_blocked,
        input  ready
    );
    modport sink (
        input  valid, command, now_ms, power_pressed, power_released, held_ms,
               any_pressed, any_released, tilt_activity, sleep_blocked,
        output ready
    );
endinterface

interface pbisc_out_if;
    logic valid;
    logic ready;
    logic returned;
    logic sleep_now;
    logic tilt_locked;
    logic tilt_changed;
    logic release_pending;
    logic power_saving_off;

    modport source (
        output valid, returned, sleep_now, tilt_locked, tilt_changed,
               release_pending, power_saving_off,
        input  ready
    );
    modport sink (
        input  valid, returned, sleep_now, tilt_locked, tilt_changed,
               release_pending, power_saving_off,
        output ready
    );
endinterface

interface pbisc_cfg_if;
    import pbisc_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_idx  index;
    t_cfg_data data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/power_button_idle_sleep_ctrl_core.sv =====
// Top level of the power-button and idle-sleep controller.
`timescale 1ns / 1ps
// Each event word on i_in yields exactly one result word on o_out. Events pass
// through an input register and a result register with combinational decision
// logic between them, so a new word is taken every cycle while o_out does not
// stall. An accepted event waits in the input register; its result word then
// sits in the result register on o_out until taken. A stall on o_out holds the
// result register, and once the input register also holds a word, i_in waits.
// Configuration writes on i_cfg are always taken and must only be issued while
// no event is in flight; writes to indexes beyond the register list are ignored.
module power_button_idle_sleep_ctrl_core (
    input  logic i_clk,
    input  logic i_rst_n,
    pbisc_in_if.sink    i_in,
    pbisc_out_if.source o_out,
    pbisc_cfg_if.sink   i_cfg
);
    import pbisc_pkg::*;

    // Configuration registers
    logic [31:0] r_true_sleep_to;
    logic [31:0] r_gyro_off_to;
    logic        r_tilt_en;
    t_ms16       r_short_press;
    t_ms16       r_wake_hold;

    // Controller state
    t_time r_sleep_allowed_at, n_sleep_allowed_at;
    t_time r_last_activity,    n_last_activity;
    logic  r_wake_wait,  n_wake_wait;
    logic  r_rel_wake,   n_rel_wake;
    logic  r_pwr_off,    n_pwr_off;
    logic  r_tilt_lock,  n_tilt_lock;

    // Input stage
    logic      r_s1_valid;
    t_cmd_bits r_cmd;
    t_time     r_now;
    logic      r_pw_pressed;
    logic      r_pw_released;
    t_ms16     r_held;
    logic      r_any_p;
    logic      r_any_r;
    logic      r_tilt_act;
    logic      r_blocked;

    // Result stage
    logic r_out_valid;
    logic r_ret, r_sleep, r_locked, r_changed, r_rel_pend, r_ps_off;
    logic n_ret, n_sleep, n_changed, n_ps_off;

    logic advance;
    logic in_fire;
    logic fire;

    // Pipeline handshake: both stages move together unless the result stalls; an empty input stage still takes a word
    assign advance     = !r_out_valid || o_out.ready;
    assign i_in.ready  = advance || !r_s1_valid;
    assign in_fire     = i_in.valid && i_in.ready;
    assign fire        = r_s1_valid && advance;
    assign i_cfg.ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_true_sleep_to <= '0;
            r_gyro_off_to   <= '0;
            r_tilt_en       <= 1'b0;
            r_short_press   <= SHORT_PRESS_RST;
            r_wake_hold     <= WAKE_HOLD_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_TRUE_SLEEP_TIMEOUT: r_true_sleep_to <= i_cfg.data;
                REG_GYRO_OFF_TIMEOUT:   r_gyro_off_to   <= i_cfg.data;
                REG_TILT_PAGE_TURN:     r_tilt_en       <= i_cfg.data[0];
                REG_SHORT_PRESS:        r_short_press   <= i_cfg.data[15:0];
                REG_WAKE_HOLD:          r_wake_hold     <= i_cfg.data[15:0];
                default: ;
            endcase
        end
    end

    // Capture the event word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd         <= i_in.command;
            r_now         <= t_time'(i_in.now_ms);
            r_pw_pressed  <= i_in.power_pressed;
            r_pw_released <= i_in.power_released;
            r_held        <= i_in.held_ms;
            r_any_p       <= i_in.any_pressed;
            r_any_r       <= i_in.any_released;
            r_tilt_act    <= i_in.tilt_activity;
            r_blocked     <= i_in.sleep_blocked;
        end
    end

    // Decide the event against the current state
    logic  hold_ok;
    logic  long_press;
    logic  long_hold;
    logic  long_release;
    t_time act_base;
    t_time idle;
    logic  true_sleep_hit;
    logic  gyro_hit;

    always_comb begin
        hold_ok      = r_rel_wake && (r_now >= r_sleep_allowed_at);
        long_press   = r_held > r_short_press;
        long_hold    = r_pw_pressed && long_press;
        long_release = r_pw_released && long_press;
        act_base     = (r_last_activity == '0) ? r_now : r_last_activity;
        idle         = r_now - act_base;
        true_sleep_hit = (r_true_sleep_to != '0) &&
                         (t_cmp'(idle) >= t_cmp'(r_true_sleep_to));
        gyro_hit       = (r_gyro_off_to != '0) && !r_tilt_lock && r_tilt_en &&
                         (t_cmp'(idle) >= t_cmp'(r_gyro_off_to));

        n_sleep_allowed_at = r_sleep_allowed_at;
        n_last_activity    = r_last_activity;
        n_wake_wait        = r_wake_wait;
        n_rel_wake         = r_rel_wake;
        n_pwr_off          = r_pwr_off;
        n_tilt_lock        = r_tilt_lock;
        n_ret              = 1'b0;
        n_sleep            = 1'b0;
        n_changed          = 1'b0;
        n_ps_off           = 1'b0;

        case (r_cmd)
            CMD_WAKE_HOLD: begin
                n_wake_wait        = 1'b1;
                n_rel_wake         = 1'b0;
                n_pwr_off          = 1'b0;
                n_sleep_allowed_at = r_now + t_time'(r_wake_hold);
                n_last_activity    = r_now;
            end
            CMD_CONSUME_RELEASE: begin
                if (r_wake_wait && !r_pw_pressed) begin
                    n_wake_wait = 1'b0;
                    n_rel_wake  = 1'b1;
                    n_pwr_off   = 1'b0;
                    n_ret       = 1'b1;
                end
            end
            CMD_NOTE_ACTIVITY: begin
                if (r_any_p || r_any_r || r_tilt_act) begin
                    n_last_activity = r_now;
                    n_ps_off        = 1'b1;
                end
                if (!r_pw_pressed) begin
                    n_rel_wake = 1'b1;
                end
            end
            CMD_POLL_HOLD: begin
                if (hold_ok && long_hold) begin
                    n_pwr_off = 1'b1;
                end
            end
            CMD_SLEEP_CHECK: begin
                n_last_activity = act_base;
                if (hold_ok && (r_pwr_off || long_hold || long_release)) begin
                    n_pwr_off = 1'b0;
                    n_sleep   = 1'b1;
                end else if (!r_blocked) begin
                    if (true_sleep_hit) begin
                        n_sleep = 1'b1;
                    end else if (gyro_hit) begin
                        n_tilt_lock = 1'b1;
                        n_changed   = 1'b1;
                    end
                end
                n_ret = n_sleep;
            end
            CMD_TILT_TOGGLE: begin
                if (!r_wake_wait) begin
                    if (r_pw_released && !long_press) begin
                        n_tilt_lock = !r_tilt_lock;
                        n_changed   = 1'b1;
                        n_ret       = 1'b1;
                    end else if (r_tilt_lock && (r_any_p || r_any_r)) begin
                        n_tilt_lock = 1'b0;
                        n_changed   = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // Commit state as the event leaves the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sleep_allowed_at <= '0;
            r_last_activity    <= '0;
            r_wake_wait        <= 1'b0;
            r_rel_wake         <= 1'b0;
            r_pwr_off          <= 1'b0;
            r_tilt_lock        <= 1'b0;
        end else if (fire) begin
            r_sleep_allowed_at <= n_sleep_allowed_at;
            r_last_activity    <= n_last_activity;
            r_wake_wait        <= n_wake_wait;
            r_rel_wake         <= n_rel_wake;
            r_pwr_off          <= n_pwr_off;
            r_tilt_lock        <= n_tilt_lock;
        end
    end

    // Hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_ret      <= n_ret;
            r_sleep    <= n_sleep;
            r_locked   <= n_tilt_lock;
            r_changed  <= n_changed;
            r_rel_pend <= n_wake_wait;
            r_ps_off   <= n_ps_off;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.returned         = r_ret;
    assign o_out.sleep_now        = r_sleep;
    assign o_out.tilt_locked      = r_locked;
    assign o_out.tilt_changed     = r_changed;
    assign o_out.release_pending  = r_rel_pend;
    assign o_out.power_saving_off = r_ps_off;

endmodule
